// ===== hw/rtl/pmt_discriminator_gated_integrator_top_assert.svh =====
// Assertion macros for the discriminator and integrator block
`ifndef PMT_DISCRIMINATOR_GATED_INTEGRATOR_TOP_ASSERT_SVH
`define PMT_DISCRIMINATOR_GATED_INTEGRATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define PDGI_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define PDGI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define PDGI_ASSERT(lbl, expr)
`define PDGI_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/pdgi_pkg.sv =====
// Shared constants and types of the discriminator and integrator block
package pdgi_pkg;
	localparam int MAX_PHOTONS = 64;
	localparam int AW = (MAX_PHOTONS > 1) ? $clog2(MAX_PHOTONS) : 1;
	localparam int CW = $clog2(MAX_PHOTONS + 1);
	localparam int SUM_W = (CW + 16 > 22) ? CW + 16 : 22;
	localparam int RESULT_LIMIT = 64;
	localparam int EW = $clog2(RESULT_LIMIT + 1);
	localparam int RAM_W = 64;
	localparam int QDEPTH = 2;
	localparam logic [21:0] CHARGE_MAX = 22'h3FFFFF;

	typedef enum logic [2:0] {
		CFG_HIT_THRESHOLD = 3'd0,
		CFG_PILEUP_WIN    = 3'd1,
		CFG_GATE_LEAD     = 3'd2,
		CFG_GATE_LEN      = 3'd3,
		CFG_NOISE_GAIN    = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] hit_threshold;
		logic [15:0] pileup_win;
		logic [15:0] gate_lead;
		logic [15:0] gate_len;
		logic [15:0] noise_gain;
	} pdgi_cfg_t;

	typedef struct packed {
		logic [15:0]   channel_id;
		logic [31:0]   photon_time;
		logic [15:0]   photon_charge;
		logic [15:0]   noise_sample;
		logic          last_photon;
		logic          store;
		logic [AW-1:0] addr;
	} pdgi_cmd_t;
endpackage

// ===== hw/rtl/pmt_discriminator_gated_integrator_top.sv =====
// Top level: photon loading, threshold scan and gated charge output
// Loading: photon beats pass through a two-entry queue; input stalls once it fills.
// Scan: per photon, read it, sum earlier entries inside the pile-up window and test the threshold;
// a crossing walks the gate back and forward over the buffer, then hands off the sample.
// A sample goes out the cycle after the next crossing or the scan end is handed off.
// Reset: asynchronous; clears queue, counts, flags, output; config to defaults; buffer undefined.
module pmt_discriminator_gated_integrator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // channel_id, photon_time, photon_charge, noise_sample
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // sample_channel, sample_time, sample_charge, 2'b0
	output logic        m_tuser,  // overflowed
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	pdgi_pkg::pdgi_cfg_t cfg_q;
	pdgi_pkg::pdgi_cmd_t push_cmd, pop_cmd;
	logic q_full, q_empty, q_push, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_threshold <= 16'd64;
			cfg_q.pileup_win    <= 16'd160;
			cfg_q.gate_lead     <= 16'd320;
			cfg_q.gate_len      <= 16'd1600;
			cfg_q.noise_gain    <= 16'd0;
		end else if (cfg_valid) begin
			unique case (pdgi_pkg::cfg_index_t'(cfg_index))
				pdgi_pkg::CFG_HIT_THRESHOLD: cfg_q.hit_threshold <= cfg_data;
				pdgi_pkg::CFG_PILEUP_WIN:    cfg_q.pileup_win    <= cfg_data;
				pdgi_pkg::CFG_GATE_LEAD:     cfg_q.gate_lead     <= cfg_data;
				pdgi_pkg::CFG_GATE_LEN:      cfg_q.gate_len      <= cfg_data;
				pdgi_pkg::CFG_NOISE_GAIN:    cfg_q.noise_gain    <= cfg_data;
				default: ;
			endcase
		end
	end

	pdgi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	pdgi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	pdgi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_cmd    (pop_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule

// ===== hw/rtl/pdgi_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module pdgi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/pdgi_front.sv =====
// Input side: takes photon beats and tags them with buffer slot or drop
module pdgi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [79:0]         s_tdata,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                q_push,
	output pdgi_pkg::pdgi_cmd_t q_cmd
);
	logic [pdgi_pkg::CW-1:0] fcnt_q;
	logic                    store;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign store    = fcnt_q < pdgi_pkg::CW'(pdgi_pkg::MAX_PHOTONS);

	always_comb begin
		q_cmd.channel_id    = s_tdata[15:0];
		q_cmd.photon_time   = s_tdata[47:16];
		q_cmd.photon_charge = s_tdata[63:48];
		q_cmd.noise_sample  = s_tdata[79:64];
		q_cmd.last_photon   = s_tlast;
		q_cmd.store         = store;
		q_cmd.addr          = fcnt_q[pdgi_pkg::AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (q_push) begin
			if (s_tlast) begin
				fcnt_q <= '0;
			end else if (store) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end
endmodule

// ===== hw/rtl/pdgi_queue.sv =====
// Two-entry command queue between front and back
module pdgi_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pdgi_pkg::pdgi_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output pdgi_pkg::pdgi_cmd_t pop_cmd
);
	pdgi_pkg::pdgi_cmd_t entry_q [pdgi_pkg::QDEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full    = cnt_q == 2'(pdgi_pkg::QDEPTH);
	assign empty   = cnt_q == 2'd0;
	assign pop_cmd = entry_q[rp_q];
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				entry_q[wp_q] <= push_cmd;
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// ===== hw/rtl/pdgi_back.sv =====
// Back end: photon buffer, window sum, threshold test, gate walk, output beat
`include "pmt_discriminator_gated_integrator_top_assert.svh"
module pdgi_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pdgi_pkg::pdgi_cfg_t cfg,
	input  logic                q_empty,
	input  pdgi_pkg::pdgi_cmd_t q_cmd,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [71:0]         m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);
	localparam int CW = pdgi_pkg::CW;
	localparam int AW = pdgi_pkg::AW;
	localparam int SW = pdgi_pkg::SUM_W;
	localparam int LW = pdgi_pkg::SUM_W + 14;
	localparam int EW_W = pdgi_pkg::EW;

	typedef enum logic [3:0] {
		S_IDLE, S_RI, S_DI, S_WR, S_WD, S_THR, S_BR, S_BD, S_FR, S_FD, S_HIT, S_END
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q, n_q, i_q, j_q, k_q;
	logic [EW_W-1:0] emit_q;
	logic [15:0]     chan_q;
	logic            ovf_q;
	logic [31:0]     now_q;
	logic [SW-1:0]   sum_q, q_q;
	logic signed [32:0] prod_q;
	logic signed [33:0] gs_q, ge_q;
	logic            held_v_q;
	logic [31:0]     held_time_q;
	logic [21:0]     held_chg_q;
	logic            out_v_q, out_last_q, out_ovf_q;
	logic [69:0]     out_data_q;

	logic [AW-1:0]     raddr;
	logic [pdgi_pkg::RAM_W-1:0] rdata;
	logic [31:0]       rtime;
	logic [15:0]       rchg;
	logic [15:0]       rnoise;
	logic              ram_we;
	logic [CW-1:0]     cnt_n, i_next;
	logic signed [32:0] win_diff;
	logic              win_in, back_in, fwd_in, hit, out_free, out_load;
	logic signed [LW-1:0] lhs, rhs;
	logic signed [33:0] gs, ge;
	logic [21:0]       q_sat;

	assign q_pop  = state_q == S_IDLE && !q_empty;
	assign ram_we = q_pop && q_cmd.store;
	assign rtime  = rdata[63:32];
	assign rchg   = rdata[31:16];
	assign rnoise = rdata[15:0];

	always_comb begin
		unique case (state_q)
			S_RI:    raddr = i_q[AW-1:0];
			S_WR:    raddr = AW'(j_q - 1'b1);
			S_BR:    raddr = AW'(k_q - 1'b1);
			default: raddr = k_q[AW-1:0];
		endcase
	end

	pdgi_ram #(.WIDTH(pdgi_pkg::RAM_W), .DEPTH(pdgi_pkg::MAX_PHOTONS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_cmd.addr),
		.wdata ({q_cmd.photon_time, q_cmd.photon_charge, q_cmd.noise_sample}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cnt_n    = q_cmd.store ? CW'(q_cmd.addr) + 1'b1 : cnt_q;
	assign win_diff = $signed({1'b0, now_q}) - $signed({1'b0, rtime});
	assign win_in   = win_diff <= $signed({17'b0, cfg.pileup_win});
	assign back_in  = $signed({2'b0, rtime}) >= gs_q;
	assign fwd_in   = $signed({2'b0, rtime}) <= ge_q;
	assign lhs      = $signed({2'b0, sum_q, 12'b0}) + LW'(prod_q);
	assign rhs      = $signed({{(SW - 14){1'b0}}, cfg.hit_threshold, 12'b0});
	assign hit      = lhs >= rhs;
	assign gs       = $signed({2'b0, now_q}) - $signed({18'b0, cfg.gate_lead});
	assign ge       = gs + $signed({18'b0, cfg.gate_len});
	assign q_sat    = (q_q > SW'(pdgi_pkg::CHARGE_MAX)) ? pdgi_pkg::CHARGE_MAX : q_q[21:0];
	assign i_next   = (k_q > i_q) ? k_q : i_q + 1'b1;
	assign out_free = !out_v_q || m_tready;
	assign out_load = (state_q == S_HIT || state_q == S_END) && held_v_q && out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b0, out_data_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			emit_q      <= '0;
			chan_q      <= '0;
			ovf_q       <= 1'b0;
			now_q       <= '0;
			sum_q       <= '0;
			q_q         <= '0;
			prod_q      <= '0;
			gs_q        <= '0;
			ge_q        <= '0;
			held_v_q    <= 1'b0;
			held_time_q <= '0;
			held_chg_q  <= '0;
			out_v_q     <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (m_tready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						chan_q <= q_cmd.channel_id;
						cnt_q  <= cnt_n;
						if (!q_cmd.store) begin
							ovf_q <= 1'b1;
						end
						if (q_cmd.last_photon) begin
							n_q    <= cnt_n;
							i_q    <= '0;
							emit_q <= '0;
							state_q <= (cnt_n == '0) ? S_END : S_RI;
						end
					end
				end
				S_RI: state_q <= S_DI;
				S_DI: begin
					now_q  <= rtime;
					sum_q  <= SW'(rchg);
					prod_q <= $signed({1'b0, cfg.noise_gain}) * $signed(rnoise);
					j_q    <= i_q;
					state_q <= (i_q != '0) ? S_WR : S_THR;
				end
				S_WR: state_q <= S_WD;
				S_WD: begin
					if (win_in) begin
						sum_q <= sum_q + SW'(rchg);
						j_q   <= j_q - 1'b1;
						state_q <= (j_q != CW'(1)) ? S_WR : S_THR;
					end else begin
						state_q <= S_THR;
					end
				end
				S_THR: begin
					if (hit) begin
						gs_q <= gs;
						ge_q <= ge;
						k_q  <= i_q;
						q_q  <= '0;
						state_q <= (i_q != '0) ? S_BR : S_FR;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 < n_q) ? S_RI : S_END;
					end
				end
				S_BR: state_q <= S_BD;
				S_BD: begin
					if (back_in) begin
						k_q <= k_q - 1'b1;
						state_q <= (k_q != CW'(1)) ? S_BR : S_FR;
					end else begin
						state_q <= S_FR;
					end
				end
				S_FR: state_q <= (k_q < n_q) ? S_FD : S_HIT;
				S_FD: begin
					if (fwd_in) begin
						q_q <= q_q + SW'(rchg);
						k_q <= k_q + 1'b1;
						state_q <= S_FR;
					end else begin
						state_q <= S_HIT;
					end
				end
				S_HIT: begin
					if (!held_v_q || out_free) begin
						if (held_v_q) begin
							out_v_q    <= 1'b1;
							out_last_q <= 1'b0;
							out_ovf_q  <= ovf_q;
							out_data_q <= {held_chg_q, held_time_q, chan_q};
						end
						held_v_q    <= 1'b1;
						held_time_q <= now_q;
						held_chg_q  <= q_sat;
						emit_q      <= emit_q + 1'b1;
						i_q         <= i_next;
						state_q <= (i_next < n_q &&
							emit_q + 1'b1 < EW_W'(pdgi_pkg::RESULT_LIMIT)) ? S_RI : S_END;
					end
				end
				S_END: begin
					if (!held_v_q || out_free) begin
						if (held_v_q) begin
							out_v_q    <= 1'b1;
							out_last_q <= 1'b1;
							out_ovf_q  <= ovf_q;
							out_data_q <= {held_chg_q, held_time_q, chan_q};
						end
						held_v_q <= 1'b0;
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PDGI_ASSERT(a_cnt_cap, cnt_q <= CW'(pdgi_pkg::MAX_PHOTONS))
	`PDGI_ASSERT_IMP(a_idle_no_held, state_q == S_IDLE, !held_v_q)
	`PDGI_ASSERT_IMP(a_fwd_in_range, state_q == S_FD, k_q < n_q)
	`PDGI_ASSERT(a_emit_cap, emit_q <= EW_W'(pdgi_pkg::RESULT_LIMIT))
endmodule
